// ===== hdl/gsq_pkg.sv =====
// Shared types, widths and handshake structs for the greedy segment sequencer.
package gsq_pkg;

    // Coordinate and store sizing.
    localparam int COORD_BITS = 24;
    localparam int SEG_BITS   = 6;
    localparam int MAX_SEG    = 1 << SEG_BITS;
    localparam int CNT_BITS   = SEG_BITS + 1;

    // Distance arithmetic widths; the distance width is the sum width, capped at 64 bits.
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int DIST_BITS  = (SUM_BITS > 64) ? 64 : SUM_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic [DIFF_BITS-1:0]         t_abs;
    typedef logic [SQ_BITS-1:0]           t_sq;
    typedef logic [SUM_BITS-1:0]          t_sum;
    typedef logic [DIST_BITS-1:0]         t_dist;
    typedef logic [SEG_BITS-1:0]          t_idx;
    typedef logic [CNT_BITS-1:0]          t_cnt;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef struct packed {
        t_point s;
        t_point e;
    } t_seg;

    // One input beat.
    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
        logic   load_last;
    } t_item;

    // One result beat.
    typedef struct packed {
        t_idx segment_index;
        logic reversed;
        logic order_last;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic seg_wr;
        t_idx wr_idx;
        t_idx rd_addr;
        logic dist_issue;
        logic check;
        logic tag;
        logic clr_best;
        logic seed_take;
        logic place_take;
        logic grow_front;
        logic ring_we;
        t_idx ring_addr;
        logic emit_rd;
        logic emit_last;
        logic clear_marks;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic want_front;
        t_idx best_idx;
    } t_dp_status;

endpackage

// ===== hdl/greedy_segment_sequencer.sv =====
// Top level of the greedy segment sequencer.
//
// Input beats are taken with start while busy is low. Each beat carries one
// segment (start and end point in 3D); beats without load_last are stored and
// give no result. Up to 64 segments are held; further points are dropped.
// The beat with load_last starts sequencing: busy rises and the chain is
// grown from the segment held in the start register (written over the cfg
// channel, which is always ready; write it only while busy is low).
// Each placement sweeps the segment store once, one entry per cycle, through
// a pair of pipelined distance units, then a side check once more than one
// segment is placed; if the growing side switches, the store is swept again.
// Then n result beats follow on consecutive cycles, each shown for one cycle
// with o_result_valid; order_last marks the final beat. The receiver cannot
// stall the results. busy falls in the cycle after the last beat.
// Reset clears the segment count, all marks and the start register to zero.
module greedy_segment_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  gsq_pkg::t_item   i_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  gsq_pkg::t_idx    i_cfg_data,
    output logic             o_result_valid,
    output gsq_pkg::t_result o_result
);

    gsq_pkg::t_dp_cmd    cmd;
    gsq_pkg::t_dp_status status;

    gsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_load_last (i_item.load_last),
        .o_busy      (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    gsq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_item),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// ===== hdl/gsq_dist.sv =====
// Three-stage pipelined squared Euclidean distance unit.
module gsq_dist (
    input  logic            i_clk,
    input  gsq_pkg::t_point i_a,
    input  gsq_pkg::t_point i_b,
    output gsq_pkg::t_dist  o_dist
);

    gsq_pkg::t_diff diff [3];
    gsq_pkg::t_abs  n_abs [3];
    gsq_pkg::t_abs  r_abs [3];
    gsq_pkg::t_sq   r_sq [3];
    gsq_pkg::t_sum  sum;
    logic           sat;
    gsq_pkg::t_dist n_dist;
    gsq_pkg::t_dist r_dist;

    // Axis differences and their magnitudes.
    always_comb begin
        diff[0] = gsq_pkg::t_diff'(i_a.x) - gsq_pkg::t_diff'(i_b.x);
        diff[1] = gsq_pkg::t_diff'(i_a.y) - gsq_pkg::t_diff'(i_b.y);
        diff[2] = gsq_pkg::t_diff'(i_a.z) - gsq_pkg::t_diff'(i_b.z);
        for (int i = 0; i < 3; i++) begin
            n_abs[i] = diff[i][gsq_pkg::DIFF_BITS-1] ? gsq_pkg::t_abs'(-diff[i])
                                                     : gsq_pkg::t_abs'(diff[i]);
        end
    end

    // Sum of squares, clamped to the largest DIST_BITS-wide value when it overflows.
    always_comb begin
        sum = gsq_pkg::t_sum'(r_sq[0]) + gsq_pkg::t_sum'(r_sq[1]) + gsq_pkg::t_sum'(r_sq[2]);
        sat = (sum >> gsq_pkg::DIST_BITS) != '0;
        n_dist = sat ? '1 : gsq_pkg::t_dist'(sum);
    end

    // Pipeline registers: magnitudes, squares, total.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_abs[i] <= n_abs[i];
            r_sq[i]  <= gsq_pkg::t_sq'(r_abs[i]) * gsq_pkg::t_sq'(r_abs[i]);
        end
        r_dist <= n_dist;
    end

    assign o_dist = r_dist;

endmodule

// ===== hdl/gsq_dp.sv =====
// Datapath: segment store, order ring, marks, chain end points and nearest search.
module gsq_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gsq_pkg::t_dp_cmd    i_cmd,
    input  gsq_pkg::t_item      i_item,
    output gsq_pkg::t_dp_status o_status,
    output logic                o_result_valid,
    output gsq_pkg::t_result    o_result
);

    gsq_pkg::t_seg   mem_seg [gsq_pkg::MAX_SEG];
    gsq_pkg::t_idx   mem_ring [gsq_pkg::MAX_SEG];
    gsq_pkg::t_seg   r_seg_q;
    gsq_pkg::t_idx   r_rd_idx;
    gsq_pkg::t_idx   r_ring_q;
    logic            r_out_v;
    logic            r_out_last;

    logic [gsq_pkg::MAX_SEG-1:0] r_used;
    logic [gsq_pkg::MAX_SEG-1:0] r_flip;
    gsq_pkg::t_point r_front_pt;
    gsq_pkg::t_point r_back_pt;

    // Search pipeline control: stage 0 is the store read, stage 3 the distance out.
    logic [3:0]      r_pv;
    logic [3:0]      r_pchk;
    logic [3:0]      r_ptag;
    gsq_pkg::t_idx   r_pidx [3];

    logic            r_found;
    gsq_pkg::t_idx   r_best_idx;
    gsq_pkg::t_dist  r_best_d;
    gsq_pkg::t_dist  r_best_d1;
    gsq_pkg::t_dist  r_best_d2;
    gsq_pkg::t_dist  r_f1;
    gsq_pkg::t_dist  r_f2;
    gsq_pkg::t_dist  r_b1;
    gsq_pkg::t_dist  r_b2;

    gsq_pkg::t_point eff_s;
    gsq_pkg::t_point eff_e;
    gsq_pkg::t_point lp;
    gsq_pkg::t_point a0;
    gsq_pkg::t_point a1;
    gsq_pkg::t_point b0;
    gsq_pkg::t_point b1;
    gsq_pkg::t_dist  d0;
    gsq_pkg::t_dist  d1;
    gsq_pkg::t_dist  fm;
    gsq_pkg::t_dist  bm;
    logic            toggle;
    logic            n_flip;
    logic            take_best;

    // Segment store: one write port for loading, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_wr) begin
            mem_seg[i_cmd.wr_idx] <= {i_item.start_x, i_item.start_y, i_item.start_z,
                                      i_item.end_x, i_item.end_y, i_item.end_z};
        end
        r_seg_q  <= mem_seg[i_cmd.rd_addr];
        r_rd_idx <= i_cmd.rd_addr;
    end

    // Order ring: written on each placement, read back in order for emission.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_we) begin
            mem_ring[i_cmd.ring_addr] <= r_rd_idx;
        end
        r_ring_q <= mem_ring[i_cmd.ring_addr];
    end

    // Effective end points of the segment just read, and the operands of both units.
    always_comb begin
        eff_s = r_flip[r_rd_idx] ? r_seg_q.e : r_seg_q.s;
        eff_e = r_flip[r_rd_idx] ? r_seg_q.s : r_seg_q.e;
        lp    = i_cmd.grow_front ? r_front_pt : r_back_pt;
        if (r_pchk[0]) begin
            a0 = r_ptag[0] ? eff_s : eff_e;
            a1 = a0;
            b0 = r_front_pt;
            b1 = r_back_pt;
        end else begin
            a0 = eff_s;
            a1 = eff_e;
            b0 = lp;
            b1 = lp;
        end
    end

    gsq_dist u_dist0 (
        .i_clk  (i_clk),
        .i_a    (a0),
        .i_b    (b0),
        .o_dist (d0)
    );

    gsq_dist u_dist1 (
        .i_clk  (i_clk),
        .i_a    (a1),
        .i_b    (b1),
        .o_dist (d1)
    );

    // Pipeline valid and tag bits; used segments drop out at issue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[2:0],
                     i_cmd.dist_issue & (i_cmd.check | ~r_used[i_cmd.rd_addr])};
        end
        r_pchk  <= {r_pchk[2:0], i_cmd.check};
        r_ptag  <= {r_ptag[2:0], i_cmd.tag};
        r_pidx[0] <= r_rd_idx;
        r_pidx[1] <= r_pidx[0];
        r_pidx[2] <= r_pidx[1];
    end

    // Running nearest candidate; the first one found wins ties.
    assign take_best = r_pv[3] & ~r_pchk[3] & (~r_found | (d0 < r_best_d) | (d1 < r_best_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.clr_best) begin
            r_found <= 1'b0;
        end else if (take_best) begin
            r_found <= 1'b1;
        end
        if (take_best) begin
            r_best_idx <= r_pidx[2];
            r_best_d   <= (d0 < d1) ? d0 : d1;
            r_best_d1  <= d0;
            r_best_d2  <= d1;
        end
        if (r_pv[3] & r_pchk[3]) begin
            if (r_ptag[3]) begin
                r_f2 <= d0;
                r_b2 <= d1;
            end else begin
                r_f1 <= d0;
                r_b1 <= d1;
            end
        end
    end

    // Side choice for the candidate, and its orientation on placement.
    always_comb begin
        fm     = (r_f1 < r_f2) ? r_f1 : r_f2;
        bm     = (r_b1 < r_b2) ? r_b1 : r_b2;
        toggle = i_cmd.grow_front ? (r_best_d1 < r_best_d2) : (r_best_d2 < r_best_d1);
        n_flip = r_flip[r_rd_idx] ^ toggle;
    end

    // Marks and chain end points.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_flip <= '0;
        end else if (i_cmd.clear_marks) begin
            r_used <= '0;
            r_flip <= '0;
        end else if (i_cmd.seed_take) begin
            r_used[r_rd_idx] <= 1'b1;
        end else if (i_cmd.place_take) begin
            r_used[r_rd_idx] <= 1'b1;
            r_flip[r_rd_idx] <= n_flip;
        end
        if (i_cmd.seed_take) begin
            r_front_pt <= r_seg_q.s;
            r_back_pt  <= r_seg_q.e;
        end else if (i_cmd.place_take) begin
            if (i_cmd.grow_front) begin
                r_front_pt <= n_flip ? r_seg_q.e : r_seg_q.s;
            end else begin
                r_back_pt  <= n_flip ? r_seg_q.s : r_seg_q.e;
            end
        end
    end

    // Result register: one beat per ring entry read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= i_cmd.emit_rd;
        end
        r_out_last <= i_cmd.emit_last;
    end

    assign o_result_valid           = r_out_v;
    assign o_result.segment_index   = r_ring_q;
    assign o_result.reversed        = r_flip[r_ring_q];
    assign o_result.order_last      = r_out_last;

    assign o_status.empty      = ~|r_pv;
    assign o_status.want_front = fm < bm;
    assign o_status.best_idx   = r_best_idx;

endmodule

// ===== hdl/gsq_ctrl.sv =====
// Controller: load counting, chain growth sequencing and emission.
module gsq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_load_last,
    output logic                o_busy,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  gsq_pkg::t_idx       i_cfg_data,
    output gsq_pkg::t_dp_cmd    o_cmd,
    input  gsq_pkg::t_dp_status i_status
);

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0000000000001,
        S_SEED_RD    = 13'b0000000000010,
        S_SEED_TAKE  = 13'b0000000000100,
        S_NEXT       = 13'b0000000001000,
        S_SWEEP      = 13'b0000000010000,
        S_SW_DRAIN   = 13'b0000000100000,
        S_CHK0       = 13'b0000001000000,
        S_CHK1       = 13'b0000010000000,
        S_CHK_DRAIN  = 13'b0000100000000,
        S_PLACE_RD   = 13'b0001000000000,
        S_PLACE_TAKE = 13'b0010000000000,
        S_EMIT       = 13'b0100000000000,
        S_EMIT_END   = 13'b1000000000000
    } t_state;

    t_state        r_state, n_state;
    gsq_pkg::t_cnt r_count, n_count;
    gsq_pkg::t_cnt r_placed, n_placed;
    gsq_pkg::t_cnt r_j, n_j;
    gsq_pkg::t_cnt r_k, n_k;
    gsq_pkg::t_idx r_head, n_head;
    gsq_pkg::t_idx r_tail, n_tail;
    logic          r_gf, n_gf;
    logic          r_switched, n_switched;
    gsq_pkg::t_idx r_start_seg;
    gsq_pkg::t_idx seed;
    logic          last_k;

    // Seed index saturates to the last loaded segment.
    assign seed = (gsq_pkg::t_cnt'(r_start_seg) < r_count) ? r_start_seg
                                                           : gsq_pkg::t_idx'(r_count - 1'b1);
    assign last_k = r_k == (r_count - 1'b1);

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_placed   = r_placed;
        n_j        = r_j;
        n_k        = r_k;
        n_head     = r_head;
        n_tail     = r_tail;
        n_gf       = r_gf;
        n_switched = r_switched;
        o_cmd            = '0;
        o_cmd.grow_front = r_gf;
        o_cmd.wr_idx     = r_count[gsq_pkg::SEG_BITS-1:0];
        o_cmd.rd_addr    = r_j[gsq_pkg::SEG_BITS-1:0];
        o_cmd.ring_addr  = r_head + r_k[gsq_pkg::SEG_BITS-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (r_count < gsq_pkg::t_cnt'(gsq_pkg::MAX_SEG)) begin
                        o_cmd.seg_wr = 1'b1;
                        n_count      = r_count + 1'b1;
                    end
                    if (i_load_last) begin
                        n_state = S_SEED_RD;
                    end
                end
            end
            S_SEED_RD: begin
                o_cmd.rd_addr = seed;
                n_state       = S_SEED_TAKE;
            end
            S_SEED_TAKE: begin
                o_cmd.seed_take = 1'b1;
                o_cmd.ring_we   = 1'b1;
                o_cmd.ring_addr = '0;
                n_head          = '0;
                n_tail          = gsq_pkg::t_idx'(1);
                n_placed        = gsq_pkg::t_cnt'(1);
                n_gf            = 1'b0;
                n_state         = S_NEXT;
            end
            S_NEXT: begin
                if (r_placed == r_count) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_switched     = 1'b0;
                    o_cmd.clr_best = 1'b1;
                    n_j            = '0;
                    n_state        = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.dist_issue = 1'b1;
                n_j              = r_j + 1'b1;
                if (r_j == (r_count - 1'b1)) begin
                    n_state = S_SW_DRAIN;
                end
            end
            S_SW_DRAIN: begin
                if (i_status.empty) begin
                    if ((r_placed > gsq_pkg::t_cnt'(1)) && !r_switched) begin
                        n_state = S_CHK0;
                    end else begin
                        n_state = S_PLACE_RD;
                    end
                end
            end
            S_CHK0: begin
                o_cmd.rd_addr    = i_status.best_idx;
                o_cmd.dist_issue = 1'b1;
                o_cmd.check      = 1'b1;
                n_state          = S_CHK1;
            end
            S_CHK1: begin
                o_cmd.rd_addr    = i_status.best_idx;
                o_cmd.dist_issue = 1'b1;
                o_cmd.check      = 1'b1;
                o_cmd.tag        = 1'b1;
                n_state          = S_CHK_DRAIN;
            end
            S_CHK_DRAIN: begin
                if (i_status.empty) begin
                    if (i_status.want_front != r_gf) begin
                        n_gf           = i_status.want_front;
                        n_switched     = 1'b1;
                        o_cmd.clr_best = 1'b1;
                        n_j            = '0;
                        n_state        = S_SWEEP;
                    end else begin
                        n_state = S_PLACE_RD;
                    end
                end
            end
            S_PLACE_RD: begin
                o_cmd.rd_addr = i_status.best_idx;
                n_state       = S_PLACE_TAKE;
            end
            S_PLACE_TAKE: begin
                o_cmd.place_take = 1'b1;
                o_cmd.ring_we    = 1'b1;
                if (r_gf) begin
                    o_cmd.ring_addr = r_head - 1'b1;
                    n_head          = r_head - 1'b1;
                end else begin
                    o_cmd.ring_addr = r_tail;
                    n_tail          = r_tail + 1'b1;
                end
                n_placed = r_placed + 1'b1;
                n_state  = S_NEXT;
            end
            S_EMIT: begin
                o_cmd.emit_rd   = 1'b1;
                o_cmd.emit_last = last_k;
                n_k             = r_k + 1'b1;
                if (last_k) begin
                    n_state = S_EMIT_END;
                end
            end
            S_EMIT_END: begin
                o_cmd.clear_marks = 1'b1;
                n_count           = '0;
                n_gf              = 1'b0;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_placed    <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_gf        <= 1'b0;
            r_switched  <= 1'b0;
            r_start_seg <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_placed   <= n_placed;
            r_j        <= n_j;
            r_k        <= n_k;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_gf       <= n_gf;
            r_switched <= n_switched;
            if (i_cfg_valid) begin
                r_start_seg <= i_cfg_data;
            end
        end
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;

endmodule
